// ----- sv/pwf_pkg.sv -----
// ----------------------------------------------------------------------------
// RC pulse width filter package
// Shared widths, constants, register indexes and types of the pulse width
// filter.
// ----------------------------------------------------------------------------
package pwf_pkg;

   localparam int TIMER_W      = 32;
   localparam int VALUE_W      = 12;
   localparam int WIDTH_W      = 15;
   localparam int QUOT_W       = 16;
   localparam int REQ_TDATA_W  = 32;
   localparam int RSP_TDATA_W  = 16;
   localparam int CSR_INDEX_W  = 2;

   localparam int AVG_DEPTH_DEF    = 8;
   localparam int TICKS_PER_US_DEF = 80;

   localparam int QUEUE_DEPTH = 2;

   localparam int RAISE_LIMIT      = 950;
   localparam int RAISE_STEP       = 1000;
   localparam int RAISE_BIAS       = 34000;
   localparam int RAISE_STEPS      = 6;
   localparam int STORE_LOW_LIMIT  = 900;
   localparam int STORE_LOW_VALUE  = 1000;
   localparam int STORE_HIGH_LIMIT = 2100;
   localparam int STORE_HIGH_VALUE = 2000;
   localparam int HIST_RESET       = 1500;

   localparam logic [CSR_INDEX_W-1:0] REG_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ACC_LOW   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ACC_HIGH  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FALLBACK  = 2'd3;

   localparam logic [VALUE_W-1:0] THRESHOLD_RESET = 12'd100;
   localparam logic [VALUE_W-1:0] ACC_LOW_RESET   = 12'd950;
   localparam logic [VALUE_W-1:0] ACC_HIGH_RESET  = 12'd2050;
   localparam logic [VALUE_W-1:0] FALLBACK_RESET  = 12'd1000;

   typedef struct packed {
      logic [VALUE_W-1:0] threshold;
      logic [VALUE_W-1:0] acc_low;
      logic [VALUE_W-1:0] acc_high;
      logic [VALUE_W-1:0] fallback;
   } cfg_type;

endpackage

// ----- sv/pwf_fifo.sv -----
// ----------------------------------------------------------------------------
// Pulse width queue
// Short queue of timer differences between the edge front end and the
// width calculation.
// ----------------------------------------------------------------------------
module pwf_fifo (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [pwf_pkg::TIMER_W-1:0] push_data,
   output logic                        full,
   output logic                        not_empty,
   input  logic                        pop,
   output logic [pwf_pkg::TIMER_W-1:0] pop_data
);
   import pwf_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);

   logic [TIMER_W-1:0] mem [0:QUEUE_DEPTH-1];
   logic [AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [AW:0]        count_ff, count_in;

   assign full      = (count_ff == (AW+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      full |-> !push || pop)
      else $error("Queue written while full.");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("Queue read while empty.");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= (AW+1)'(QUEUE_DEPTH))
      else $error("Queue fill count beyond its depth.");

endmodule

// ----- sv/pwf_front.sv -----
// ----------------------------------------------------------------------------
// Edge front end
// Accepts edge events, tracks the armed state and the start time, and
// queues the timer difference of every completed pulse.
// ----------------------------------------------------------------------------
module pwf_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic                        req_level,
   input  logic [pwf_pkg::TIMER_W-1:0] req_timer,
   output logic                        push,
   output logic [pwf_pkg::TIMER_W-1:0] push_ticks,
   input  logic                        queue_full
);
   import pwf_pkg::*;

   logic               armed_ff, armed_in;
   logic [TIMER_W-1:0] start_ff, start_in;
   logic               accept;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept && !req_level && armed_ff;
   assign push_ticks = start_ff - req_timer;

   always_comb begin
      armed_in = armed_ff;
      start_in = start_ff;
      if (accept) begin
         if (req_level) begin
            if (!armed_ff) begin
               armed_in = 1'b1;
               start_in = req_timer;
            end
         end else begin
            armed_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
         start_ff <= '0;
      end else begin
         armed_ff <= armed_in;
         start_ff <= start_in;
      end
   end

   a_rise_keeps_start : assert property (@(posedge clock) disable iff (reset)
      accept && req_level && armed_ff |=> $stable(start_ff) && armed_ff)
      else $error("Start time changed by a rising edge while armed.");

   a_push_disarms : assert property (@(posedge clock) disable iff (reset)
      push |=> !armed_ff)
      else $error("Still armed after a completed pulse.");

   a_rise_arms : assert property (@(posedge clock) disable iff (reset)
      accept && req_level |=> armed_ff)
      else $error("Rising edge did not arm the capture.");

endmodule

// ----- sv/pwf_div.sv -----
// ----------------------------------------------------------------------------
// Tick divider
// Divides the timer difference by the ticks per microsecond, eight quotient
// bits per cycle while a division runs.
// ----------------------------------------------------------------------------
module pwf_div #(
   parameter int TICKS_PER_US = pwf_pkg::TICKS_PER_US_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [pwf_pkg::TIMER_W-1:0] in_ticks,
   output logic                        in_pop,
   output logic                        out_valid,
   output logic [pwf_pkg::QUOT_W-1:0]  out_quot,
   input  logic                        out_ready
);
   import pwf_pkg::*;

   localparam int RW = $clog2(TICKS_PER_US) + 1;
   localparam logic [RW:0] DIVISOR = (RW+1)'(TICKS_PER_US);

   logic               busy_ff, busy_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic [RW-1:0]      rem_ff, rem_in;
   logic [TIMER_W-1:0] num_ff, num_in;
   logic               done;
   logic               load;
   logic [RW+7:0]      step_first;
   logic [RW+7:0]      step_next;

   function automatic logic [RW+7:0] div_step(input logic [RW-1:0] r,
                                              input logic [7:0] bits);
      logic [RW:0]   rx;
      logic [RW-1:0] t;
      logic [7:0]    q;
      t = r;
      q = '0;
      for (int i = 7; i >= 0; i--) begin
         rx = {t, bits[i]};
         if (rx >= DIVISOR) begin
            rx   = rx - DIVISOR;
            q[i] = 1'b1;
         end
         t = rx[RW-1:0];
      end
      return {t, q};
   endfunction

   assign done       = busy_ff && (cnt_ff == 2'd0);
   assign out_valid  = done;
   assign out_quot   = num_ff[QUOT_W-1:0];
   assign load       = in_valid && (!busy_ff || (done && out_ready));
   assign in_pop     = load;
   assign step_first = div_step('0, in_ticks[TIMER_W-1 -: 8]);
   assign step_next  = div_step(rem_ff, num_ff[TIMER_W-1 -: 8]);

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      if (load) begin
         busy_in = 1'b1;
         cnt_in  = 2'd1;
         rem_in  = step_first[RW+7:8];
         num_in  = {in_ticks[TIMER_W-9:0], step_first[7:0]};
      end else if (done) begin
         if (out_ready) begin
            busy_in = 1'b0;
         end
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 2'd1;
         rem_in = step_next[RW+7:8];
         num_in = {num_ff[TIMER_W-9:0], step_next[7:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      num_ff <= num_in;
   end

   a_hold_result : assert property (@(posedge clock) disable iff (reset)
      done && !out_ready && !load |=> done && $stable(num_ff))
      else $error("Quotient lost while the next stage stalled.");

   a_load_when_free : assert property (@(posedge clock) disable iff (reset)
      load |-> !busy_ff || (done && out_ready))
      else $error("Division started over one still in progress.");

   a_four_steps : assert property (@(posedge clock) disable iff (reset)
      load |=> busy_ff && !done ##1 !done ##1 !done ##1 done)
      else $error("Division did not take four cycles.");

endmodule

// ----- sv/pwf_filter.sv -----
// ----------------------------------------------------------------------------
// Width filter
// Raises the width into range, keeps the history line and its running sum,
// replaces outliers by the history average and applies the acceptance
// window.
// ----------------------------------------------------------------------------
module pwf_filter #(
   parameter int AVG_DEPTH = pwf_pkg::AVG_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pwf_pkg::cfg_type            cfg,
   input  logic                        in_valid,
   input  logic [pwf_pkg::QUOT_W-1:0]  in_quot,
   output logic                        in_ready,
   output logic                        out_valid,
   output logic [pwf_pkg::VALUE_W-1:0] out_value,
   input  logic                        out_ready
);
   import pwf_pkg::*;

   localparam int LD = $clog2(AVG_DEPTH);
   localparam int SW = VALUE_W + LD;
   localparam int SH = SW + LD;
   localparam int MW = SW + 1;
   localparam int PW = SW + MW;
   localparam logic [MW-1:0] AVG_MULT = MW'(((64'd1 << SH) + AVG_DEPTH - 1) / AVG_DEPTH);

   logic                r_valid_ff, r_valid_in;
   logic [WIDTH_W-1:0]  r_w_ff, r_w_in;
   logic                h_valid_ff, h_valid_in;
   logic [WIDTH_W-1:0]  h_w_ff, h_w_in;
   logic [PW-1:0]       h_prod_ff, h_prod_in;
   logic                o_valid_ff, o_valid_in;
   logic [VALUE_W-1:0]  o_value_ff, o_value_in;
   logic [VALUE_W-1:0]  hist_ff [0:AVG_DEPTH];
   logic [VALUE_W-1:0]  hist_in [0:AVG_DEPTH];
   logic [SW-1:0]       sum_ff, sum_in;

   logic                o_ready;
   logic                h_move;
   logic                h_ready;
   logic                r_move;
   logic                r_load;
   logic signed [15:0]  w16;
   logic [16:0]         x;
   logic [16:0]         c;
   logic [WIDTH_W-1:0]  raised;
   logic [VALUE_W-1:0]  stored;
   logic [VALUE_W-1:0]  avg;
   logic signed [16:0]  diff;
   logic [16:0]         diff_abs;
   logic [WIDTH_W-1:0]  w_sel;

   assign o_ready   = !o_valid_ff || out_ready;
   assign h_move    = h_valid_ff && o_ready;
   assign h_ready   = !h_valid_ff || o_ready;
   assign r_move    = r_valid_ff && h_ready;
   assign in_ready  = !r_valid_ff || h_ready;
   assign r_load    = in_valid && in_ready;
   assign out_valid = o_valid_ff;
   assign out_value = o_value_ff;

   always_comb begin
      w16 = $signed(in_quot);
      x   = '0;
      c   = '0;
      if (w16 <= $signed(16'(RAISE_LIMIT))) begin
         x = 17'($signed({w16[15], w16}) + $signed(17'(RAISE_BIAS)));
         for (int k = RAISE_STEPS - 1; k >= 0; k--) begin
            c = 17'(RAISE_STEP) << k;
            if (x >= 17'(RAISE_LIMIT + 1) + c) begin
               x = x - c;
            end
         end
         raised = x[WIDTH_W-1:0];
      end else begin
         raised = w16[WIDTH_W-1:0];
      end
   end

   always_comb begin
      if (r_w_ff < WIDTH_W'(STORE_LOW_LIMIT)) begin
         stored = VALUE_W'(STORE_LOW_VALUE);
      end else if (r_w_ff > WIDTH_W'(STORE_HIGH_LIMIT)) begin
         stored = VALUE_W'(STORE_HIGH_VALUE);
      end else begin
         stored = r_w_ff[VALUE_W-1:0];
      end
   end

   always_comb begin
      avg      = h_prod_ff[SH +: VALUE_W];
      diff     = $signed({5'b0, avg}) - $signed({2'b0, h_w_ff});
      diff_abs = diff[16] ? 17'(-diff) : 17'(diff);
      if (diff_abs > {5'b0, cfg.threshold}) begin
         w_sel = {3'b0, avg};
      end else begin
         w_sel = h_w_ff;
      end
   end

   always_comb begin
      r_valid_in = r_valid_ff;
      r_w_in     = r_w_ff;
      h_valid_in = h_valid_ff;
      h_w_in     = h_w_ff;
      h_prod_in  = h_prod_ff;
      o_valid_in = o_valid_ff;
      o_value_in = o_value_ff;
      sum_in     = sum_ff;
      for (int i = 0; i <= AVG_DEPTH; i++) begin
         hist_in[i] = hist_ff[i];
      end
      if (r_move) begin
         r_valid_in = 1'b0;
      end
      if (r_load) begin
         r_valid_in = 1'b1;
         r_w_in     = raised;
      end
      if (h_move) begin
         h_valid_in = 1'b0;
      end
      if (r_move) begin
         h_valid_in = 1'b1;
         h_w_in     = r_w_ff;
         h_prod_in  = PW'(sum_ff) * PW'(AVG_MULT);
         sum_in     = sum_ff - SW'(hist_ff[0]) + SW'(hist_ff[AVG_DEPTH]);
         for (int i = 0; i < AVG_DEPTH; i++) begin
            hist_in[i] = hist_ff[i+1];
         end
         hist_in[AVG_DEPTH] = stored;
      end
      if (o_valid_ff && out_ready) begin
         o_valid_in = 1'b0;
      end
      if (h_move) begin
         o_valid_in = 1'b1;
         if ((w_sel > {3'b0, cfg.acc_low}) && (w_sel < {3'b0, cfg.acc_high})) begin
            o_value_in = w_sel[VALUE_W-1:0];
         end else begin
            o_value_in = cfg.fallback;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
         h_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
         sum_ff     <= SW'(HIST_RESET * AVG_DEPTH);
         for (int i = 0; i <= AVG_DEPTH; i++) begin
            hist_ff[i] <= VALUE_W'(HIST_RESET);
         end
      end else begin
         r_valid_ff <= r_valid_in;
         h_valid_ff <= h_valid_in;
         o_valid_ff <= o_valid_in;
         sum_ff     <= sum_in;
         for (int i = 0; i <= AVG_DEPTH; i++) begin
            hist_ff[i] <= hist_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      r_w_ff     <= r_w_in;
      h_w_ff     <= h_w_in;
      h_prod_ff  <= h_prod_in;
      o_value_ff <= o_value_in;
   end

   a_raised_range : assert property (@(posedge clock) disable iff (reset)
      r_valid_ff |-> r_w_ff > WIDTH_W'(RAISE_LIMIT))
      else $error("Raised width not above the raise limit.");

   a_stored_range : assert property (@(posedge clock) disable iff (reset)
      r_move |=> hist_ff[AVG_DEPTH] >= VALUE_W'(STORE_LOW_LIMIT)
                 && hist_ff[AVG_DEPTH] <= VALUE_W'(STORE_HIGH_LIMIT))
      else $error("History entry outside its bounded range.");

   a_stage_hold : assert property (@(posedge clock) disable iff (reset)
      h_valid_ff && !o_ready |=> h_valid_ff && $stable(h_w_ff) && $stable(sum_ff))
      else $error("Filter stage changed while stalled.");

endmodule

// ----- sv/rc_pulse_width_filter_top.sv -----
// Flow: a falling edge that ends a pulse passes from req through the queue, the tick
// divider and the filter's raise, history and output registers to rsp_tvalid. Edges are
// taken one per cycle while the queue has room; the tick divider produces eight quotient
// bits per cycle and can take the next pulse in the cycle its quotient is taken.
// Reset: synchronous; clears the armed state, the queue and the pipeline, loads every
// history entry with 1500 and the registers with their defaults.
// ----------------------------------------------------------------------------
// RC pulse width filter top level
// Measures RC pulse widths from edge events, filters outliers against the
// history average and applies the acceptance window.
// ----------------------------------------------------------------------------
module rc_pulse_width_filter_top #(
   parameter int AVG_DEPTH    = pwf_pkg::AVG_DEPTH_DEF,
   parameter int TICKS_PER_US = pwf_pkg::TICKS_PER_US_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [pwf_pkg::REQ_TDATA_W-1:0] req_tdata,  // [31:0] timer_value
   input  logic [0:0]                      req_tuser,  // [0] level
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [pwf_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // [11:0] channel_value
   input  logic                            csr_wen,
   input  logic [pwf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pwf_pkg::VALUE_W-1:0]     csr_wdata
);
   import pwf_pkg::*;

   cfg_type            cfg_ff, cfg_in;
   logic               push;
   logic [TIMER_W-1:0] push_ticks;
   logic               q_full;
   logic               q_not_empty;
   logic               q_pop;
   logic [TIMER_W-1:0] q_data;
   logic               div_valid;
   logic [QUOT_W-1:0]  div_quot;
   logic               div_ready;
   logic [VALUE_W-1:0] value;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            REG_THRESHOLD: cfg_in.threshold = csr_wdata;
            REG_ACC_LOW:   cfg_in.acc_low   = csr_wdata;
            REG_ACC_HIGH:  cfg_in.acc_high  = csr_wdata;
            REG_FALLBACK:  cfg_in.fallback  = csr_wdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold <= THRESHOLD_RESET;
         cfg_ff.acc_low   <= ACC_LOW_RESET;
         cfg_ff.acc_high  <= ACC_HIGH_RESET;
         cfg_ff.fallback  <= FALLBACK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pwf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_level  (req_tuser[0]),
      .req_timer  (req_tdata[TIMER_W-1:0]),
      .push       (push),
      .push_ticks (push_ticks),
      .queue_full (q_full)
   );

   pwf_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_ticks),
      .full      (q_full),
      .not_empty (q_not_empty),
      .pop       (q_pop),
      .pop_data  (q_data)
   );

   pwf_div #(
      .TICKS_PER_US (TICKS_PER_US)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_not_empty),
      .in_ticks  (q_data),
      .in_pop    (q_pop),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_ready (div_ready)
   );

   pwf_filter #(
      .AVG_DEPTH (AVG_DEPTH)
   ) u_filter (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (div_valid),
      .in_quot   (div_quot),
      .in_ready  (div_ready),
      .out_valid (rsp_tvalid),
      .out_value (value),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {(RSP_TDATA_W - VALUE_W)'(0), value};

endmodule

// ----- tb/rc_pulse_width_filter_top_tb.sv -----
// ----------------------------------------------------------------------------
// RC pulse width filter testbench
// Drives rising and falling edge events with timer samples into the filter
// and measures each completed pulse with a local model of the capture,
// history average, outlier replacement and acceptance window. Every
// filtered width on the result stream is compared with the model's oldest
// pending width. Both streams stall at random outside the steady phase, and the
// registers are reloaded between phases, extremes included.
// ----------------------------------------------------------------------------
module rc_pulse_width_filter_top_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import pwf_pkg::*;

   localparam int AVG_DEPTH     = AVG_DEPTH_DEF;
   localparam int TICKS_PER_US  = TICKS_PER_US_DEF;
   localparam int IDLE_PERCENT  = 27;
   localparam int RANDOM_EDGES  = 315;
   localparam int DRAIN_CYCLES  = 12;
   localparam int STALL_LIMIT   = 4000;

   typedef struct packed {
      logic               level;
      logic [TIMER_W-1:0] timer;
   } pin_event_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [0:0]             req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_wen    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [VALUE_W-1:0]     csr_wdata  = '0;

   pin_event_type      pin_events[$];
   logic [VALUE_W-1:0] filtered_widths[$];
   int                 presented_events = 0;
   int                 taken_events     = 0;
   int                 stall_cycles     = 0;
   int                 error_count      = 0;
   bit                 steady           = 1'b0;

   bit                 pulse_armed;
   logic [TIMER_W-1:0] capture_start;
   logic [VALUE_W-1:0] width_history[0:AVG_DEPTH];
   cfg_type            filter_cfg;

   rc_pulse_width_filter_top #(
      .AVG_DEPTH   (AVG_DEPTH),
      .TICKS_PER_US(TICKS_PER_US)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      error_count++;
   endtask

   function automatic bit measure_pulse(input logic level, input logic [TIMER_W-1:0] timer,
                                        output logic [VALUE_W-1:0] value);
      logic [TIMER_W-1:0] ticks;
      logic [TIMER_W-1:0] micros;
      int width;
      int total;
      int average;
      int deviation;
      value = '0;
      if (level) begin
         if (!pulse_armed) begin
            capture_start = timer;
            pulse_armed   = 1'b1;
         end
         return 1'b0;
      end
      if (!pulse_armed)
         return 1'b0;
      pulse_armed = 1'b0;
      ticks  = capture_start - timer;
      micros = ticks / TICKS_PER_US;
      width  = int'($signed(micros[15:0]));
      if (width <= RAISE_LIMIT)
         width += ((RAISE_LIMIT + 1 - width + RAISE_STEP - 1) / RAISE_STEP) * RAISE_STEP;
      total = 0;
      for (int i = 0; i < AVG_DEPTH; i++) begin
         total += int'(width_history[i]);
         width_history[i] = width_history[i + 1];
      end
      if (width < STORE_LOW_LIMIT)
         width_history[AVG_DEPTH] = VALUE_W'(STORE_LOW_VALUE);
      else if (width > STORE_HIGH_LIMIT)
         width_history[AVG_DEPTH] = VALUE_W'(STORE_HIGH_VALUE);
      else
         width_history[AVG_DEPTH] = width[VALUE_W-1:0];
      average   = total / AVG_DEPTH;
      deviation = (average > width) ? average - width : width - average;
      if (deviation > int'(filter_cfg.threshold))
         width = average;
      if (width > int'(filter_cfg.acc_low) && width < int'(filter_cfg.acc_high))
         value = width[VALUE_W-1:0];
      else
         value = filter_cfg.fallback;
      return 1'b1;
   endfunction

   always @(posedge clock) begin : monitor
      logic [VALUE_W-1:0] value;
      logic [VALUE_W-1:0] wanted;
      bit produced;
      if (reset) begin
         pulse_armed   = 1'b0;
         capture_start = '0;
         for (int i = 0; i <= AVG_DEPTH; i++)
            width_history[i] = VALUE_W'(HIST_RESET);
         filter_cfg = '{THRESHOLD_RESET, ACC_LOW_RESET, ACC_HIGH_RESET, FALLBACK_RESET};
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (csr_wen) begin
            case (csr_index)
               REG_THRESHOLD: filter_cfg.threshold = csr_wdata;
               REG_ACC_LOW:   filter_cfg.acc_low   = csr_wdata;
               REG_ACC_HIGH:  filter_cfg.acc_high  = csr_wdata;
               REG_FALLBACK:  filter_cfg.fallback  = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            taken_events++;
            stall_cycles = 0;
            produced = measure_pulse(req_tuser[0], req_tdata, value);
            if (produced)
               filtered_widths.push_back(value);
         end
         if (rsp_tvalid && rsp_tready) begin
            stall_cycles = 0;
            if (filtered_widths.size() == 0) begin
               report_mismatch($sformatf("result transfer %0d with none pending",
                                         rsp_tdata[VALUE_W-1:0]));
            end else begin
               wanted = filtered_widths.pop_front();
               if (rsp_tdata[VALUE_W-1:0] !== wanted)
                  report_mismatch($sformatf("channel_value %0d, model gives %0d",
                                            rsp_tdata[VALUE_W-1:0], wanted));
            end
         end
      end
   end

   always @(negedge clock) begin : driver
      pin_event_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && taken_events < presented_events)) begin
         if (pin_events.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            item = pin_events.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= item.timer;
            req_tuser  <= item.level;
            presented_events++;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   task automatic queue_event(input logic level, input logic [TIMER_W-1:0] timer);
      pin_events.push_back('{level, timer});
   endtask

   task automatic queue_pulse(input logic [TIMER_W-1:0] start, input logic [TIMER_W-1:0] ticks);
      queue_event(1'b1, start);
      queue_event(1'b0, start - ticks);
   endtask

   function automatic logic [TIMER_W-1:0] random_ticks();
      int pick;
      logic [TIMER_W-1:0] micros;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         micros = $urandom_range(850, 2150);
      else if (pick < 80)
         micros = $urandom_range(1400, 1600);
      else if (pick < 95)
         micros = $urandom_range(0, 70000);
      else
         return $urandom;
      return micros * TICKS_PER_US + $urandom_range(0, TICKS_PER_US - 1);
   endfunction

   task automatic queue_random_events(input int count);
      int added;
      int pick;
      logic [TIMER_W-1:0] start;
      added = 0;
      while (added < count) begin
         pick  = $urandom_range(0, 99);
         start = $urandom;
         if (pick < 80) begin
            queue_pulse(start, random_ticks());
            added += 2;
         end else if (pick < 88) begin
            queue_event(1'($urandom_range(0, 1)), $urandom);
            added++;
         end else if (pick < 94) begin
            queue_event(1'b1, start);
            queue_event(1'b1, $urandom);
            queue_event(1'b0, start - random_ticks());
            added += 3;
         end else begin
            queue_event(1'b0, start);
            queue_event(1'b0, $urandom);
            added += 2;
         end
      end
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input int value);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= index;
      csr_wdata <= value[VALUE_W-1:0];
      @(negedge clock);
      csr_wen   <= 1'b0;
   endtask

   task automatic load_settings(input int threshold, input int low, input int high,
                                input int fallback);
      write_reg(REG_THRESHOLD, threshold);
      write_reg(REG_ACC_LOW, low);
      write_reg(REG_ACC_HIGH, high);
      write_reg(REG_FALLBACK, fallback);
   endtask

   // A rising edge gives no result, so the pipeline is given time to settle
   // after the last pending width has been seen.
   task automatic drain();
      while (pin_events.size() != 0 || taken_events != presented_events ||
             filtered_widths.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      while (stall_cycles < STALL_LIMIT)
         @(posedge clock);
      $display("rc_pulse_width_filter_top_tb failed");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_event(1'b0, '0);
      queue_event(1'b1, '1);
      queue_event(1'b1, '0);
      queue_event(1'b0, 32'hFFFF_FFFF - 1500 * TICKS_PER_US);
      queue_pulse('0, 1000 * TICKS_PER_US);
      queue_pulse(32'h1234_5678, '0);
      queue_pulse(32'h8000_0000, 950 * TICKS_PER_US);
      queue_pulse(32'h0000_FFFF, 951 * TICKS_PER_US);
      queue_pulse(32'h7FFF_FFFF, 2101 * TICKS_PER_US);
      queue_pulse(32'h5555_5555, 2100 * TICKS_PER_US + TICKS_PER_US - 1);
      queue_pulse(32'hAAAA_AAAA, 32767 * TICKS_PER_US);
      queue_pulse(32'hFFFF_FFFF, 32768 * TICKS_PER_US);
      queue_pulse(32'h0F0F_0F0F, 65535 * TICKS_PER_US);
      queue_pulse(32'hF0F0_F0F0, 32'hFFFF_FFFF);
      queue_pulse(32'h0000_1000, 1700 * TICKS_PER_US);
      drain();

      load_settings(0, 0, 4095, 4095);
      queue_random_events(RANDOM_EDGES);
      drain();

      load_settings(4095, 4095, 0, 0);
      queue_random_events(RANDOM_EDGES);
      drain();

      steady = 1'b1;
      load_settings(int'(THRESHOLD_RESET), int'(ACC_LOW_RESET), int'(ACC_HIGH_RESET),
                    int'(FALLBACK_RESET));
      queue_random_events(RANDOM_EDGES);
      drain();
      steady = 1'b0;

      for (int phase = 0; phase < 2; phase++) begin
         load_settings($urandom_range(0, 400), $urandom_range(800, 1200),
                       $urandom_range(1800, 2200), $urandom_range(0, 4095));
         queue_random_events(RANDOM_EDGES);
         drain();
      end

      load_settings($urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 4095), $urandom_range(0, 4095));
      queue_random_events(RANDOM_EDGES);
      drain();

      if (error_count == 0 && filtered_widths.size() == 0)
         $display("rc_pulse_width_filter_top_tb passed");
      else
         $display("rc_pulse_width_filter_top_tb failed");
      $finish;
   end

endmodule
